FILE: hdl/cde_pkg.sv
`default_nettype none

package cde_pkg;

    // Field widths
    localparam int unsigned VAL_W  = 32;
    localparam int unsigned MODE_W = 3;
    localparam int unsigned OCC_W  = 5;

    // Defaults and limits
    localparam int unsigned DEPTH_DEF = 16;
    localparam int unsigned CAP_MAX   = (1 << OCC_W) - 1;
    localparam int unsigned CAP_RESET = 16;

    // Request operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_INS_FRONT = 3'd0,
        MODE_INS_BACK  = 3'd1,
        MODE_DEL_FRONT = 3'd2,
        MODE_DEL_BACK  = 3'd3,
        MODE_QUERY     = 3'd4
    } mode_t;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic             push_front;
        logic             pop_front;
        logic             push_back;
        logic [OCC_W-1:0] count;
        logic [OCC_W-1:0] count_next;
        logic [VAL_W-1:0] value;
    } cell_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/cde_if.sv
`default_nettype none

// Request channel: operation and value
interface cde_req_if import cde_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [MODE_W-1:0]       mode;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, mode, value, input ready);
    modport sink   (input valid, mode, value, output ready);
endinterface

// Response channel: outcome and queue state after the request
interface cde_rsp_if import cde_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    success;
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] rear_value;
    logic                    is_empty;
    logic                    is_full;
    logic [OCC_W-1:0]        occupancy;

    modport source (output valid, success, front_value, rear_value, is_empty, is_full,
                    occupancy, input ready);
    modport sink   (input valid, success, front_value, rear_value, is_empty, is_full,
                    occupancy, output ready);
endinterface

`default_nettype wire

FILE: hdl/cde_cell.sv
`default_nettype none

// One slot of the deque; slot 0 is the front entry.
module cde_cell import cde_pkg::*; #(
    parameter int unsigned IDX = 0
) (
    input  wire logic             clk,
    input  wire cell_ctl_t        ctl,
    input  wire logic [VAL_W-1:0] left_data,
    input  wire logic [VAL_W-1:0] right_data,
    input  wire logic [VAL_W-1:0] rear_in,
    output logic      [VAL_W-1:0] data,
    output logic      [VAL_W-1:0] data_nxt,
    output logic      [VAL_W-1:0] rear_out
);

    localparam logic [OCC_W-1:0] POS      = OCC_W'(IDX);
    localparam logic [OCC_W-1:0] POS_LAST = OCC_W'(IDX + 1);

    logic [VAL_W-1:0] data_reg;
    logic [VAL_W-1:0] data_next;
    logic             is_rear;

    // Shift toward the back on front insert, toward the front on front delete
    always_comb
    begin
        if (ctl.push_front)
        begin
            data_next = left_data;
        end
        else if (ctl.pop_front)
        begin
            data_next = right_data;
        end
        else if (ctl.push_back && (ctl.count == POS))
        begin
            data_next = ctl.value;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // Rear entry pick travels down the row
    assign is_rear  = (ctl.count_next == POS_LAST);
    assign rear_out = rear_in | (data_next & {VAL_W{is_rear}});
    assign data     = data_reg;
    assign data_nxt = data_next;

endmodule

`default_nettype wire

FILE: hdl/circular_deque_engine.sv
`default_nettype none

// Double-ended queue built as a row of shifting cells.
// req channel: one request per handshake, mode (insert front/back, delete
//   front/back, query) and a 32-bit value used only by inserts.
// rsp channel: one response per request with success, front and rear
//   values (-1 when empty), empty/full flags and the occupancy after it.
// Latency: the response is valid the cycle after the request is taken.
// Throughput: one request per cycle while responses drain; each request
//   updates every cell in one step; the rear is picked along the cell row.
// The response sits in an output register; a new request is taken when
//   that register is empty or being drained, so a stalled receiver holds
//   the request side off after one pending response.
// cfg_wr_en/cfg_wr_data write the capacity (0 reads as 1, values above the
//   built depth saturate) and empty the queue; write it only while idle.
// Reset: asynchronous, empties the queue, sets capacity to 16 (or the
//   built depth if smaller) and drops any pending response. No clearing
//   pass is needed; slot contents are only read once written.
module circular_deque_engine import cde_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    cde_req_if.sink               req,
    cde_rsp_if.source             rsp,
    input  wire logic             cfg_wr_en,
    input  wire logic [OCC_W-1:0] cfg_wr_data
);

    localparam int unsigned NCELL = (DEPTH < CAP_MAX) ? DEPTH : CAP_MAX;
    localparam logic [OCC_W-1:0] CAP_TOP  = OCC_W'(NCELL);
    localparam logic [OCC_W-1:0] CAP_INIT =
        OCC_W'((CAP_RESET < NCELL) ? CAP_RESET : NCELL);
    localparam logic [OCC_W-1:0] ONE = OCC_W'(1);

    logic [OCC_W-1:0] cap_reg;
    logic [OCC_W-1:0] count_reg;
    logic [OCC_W-1:0] count_next;
    logic [OCC_W-1:0] cap_wr;

    logic             rsp_valid_reg;
    logic             success_reg;
    logic [VAL_W-1:0] front_reg;
    logic [VAL_W-1:0] rear_reg;
    logic             empty_reg;
    logic             full_reg;
    logic [OCC_W-1:0] occ_reg;

    logic             accept;
    logic             full;
    logic             empty;
    logic             ok;
    logic             do_push_front;
    logic             do_push_back;
    logic             do_pop_front;
    logic             do_pop_back;
    cell_ctl_t        ctl;

    logic [VAL_W-1:0] cell_data [NCELL];
    logic [VAL_W-1:0] cell_nxt  [NCELL];
    logic [VAL_W-1:0] rear_chain [NCELL+1];

    // Handshake
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign full  = (count_reg >= cap_reg);
    assign empty = (count_reg == '0);

    // Request decode
    always_comb
    begin
        do_push_front = 1'b0;
        do_push_back  = 1'b0;
        do_pop_front  = 1'b0;
        do_pop_back   = 1'b0;
        ok            = 1'b1;
        unique case (mode_t'(req.mode))
            MODE_INS_FRONT:
            begin
                ok            = !full;
                do_push_front = !full;
            end
            MODE_INS_BACK:
            begin
                ok           = !full;
                do_push_back = !full;
            end
            MODE_DEL_FRONT:
            begin
                ok           = !empty;
                do_pop_front = !empty;
            end
            MODE_DEL_BACK:
            begin
                ok          = !empty;
                do_pop_back = !empty;
            end
            MODE_QUERY:
            begin
                ok = 1'b1;
            end
            default:
            begin
                ok = 1'b1;
            end
        endcase
    end

    // Occupancy after this request
    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (do_push_front || do_push_back)
            begin
                count_next = count_reg + ONE;
            end
            else if (do_pop_front || do_pop_back)
            begin
                count_next = count_reg - ONE;
            end
        end
    end

    // Control broadcast to the cells
    always_comb
    begin
        ctl.push_front = accept && do_push_front;
        ctl.pop_front  = accept && do_pop_front;
        ctl.push_back  = accept && do_push_back;
        ctl.count      = count_reg;
        ctl.count_next = count_next;
        ctl.value      = req.value;
    end

    // Cell row
    assign rear_chain[0] = '0;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        logic [VAL_W-1:0] left_w;
        logic [VAL_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = req.value;
        end
        else
        begin : g_mid
            assign left_w = cell_data[i-1];
        end

        if (i == NCELL - 1)
        begin : g_last
            assign right_w = cell_data[i];
        end
        else
        begin : g_inner
            assign right_w = cell_data[i+1];
        end

        cde_cell #(
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .left_data  (left_w),
            .right_data (right_w),
            .rear_in    (rear_chain[i]),
            .data       (cell_data[i]),
            .data_nxt   (cell_nxt[i]),
            .rear_out   (rear_chain[i+1])
        );
    end

    // Capacity as written, clamped to 1..built depth
    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            cap_wr = ONE;
        end
        else if (cfg_wr_data > CAP_TOP)
        begin
            cap_wr = CAP_TOP;
        end
        else
        begin
            cap_wr = cfg_wr_data;
        end
    end

    // Queue state and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_INIT;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg   <= cap_wr;
                count_reg <= '0;
            end
            else
            begin
                count_reg <= count_next;
            end

            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            success_reg <= ok;
            empty_reg   <= (count_next == '0);
            full_reg    <= (count_next >= cap_reg);
            occ_reg     <= count_next;
            if (count_next == '0)
            begin
                front_reg <= '1;
                rear_reg  <= '1;
            end
            else
            begin
                front_reg <= cell_nxt[0];
                rear_reg  <= rear_chain[NCELL];
            end
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.success     = success_reg;
    assign rsp.front_value = front_reg;
    assign rsp.rear_value  = rear_reg;
    assign rsp.is_empty    = empty_reg;
    assign rsp.is_full     = full_reg;
    assign rsp.occupancy   = occ_reg;

`ifndef SYNTHESIS
    // Occupancy never passes the configured capacity
    a_count_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_reg)
        else $error("occupancy above capacity");

    // Every taken request yields a response next cycle
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("response missing after request");

    // Capacity write empties the queue
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> (count_reg == '0))
        else $error("capacity write did not empty queue");

    // A failed request leaves occupancy alone
    a_fail_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !ok && !cfg_wr_en) |=> $stable(count_reg))
        else $error("failed request changed occupancy");

    // Empty response reports zero occupancy and -1 at both ends
    a_empty_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && empty_reg) |->
            ((occ_reg == '0) && (front_reg == '1) && (rear_reg == '1)))
        else $error("empty response inconsistent");
`endif

endmodule

`default_nettype wire
